// ----- rtl/fbla_pkg.sv -----
`default_nettype none
package fbla_pkg;

	// Field widths of the item and result channels.
	localparam int OP_W       = 2;
	localparam int BLK_W      = 10;
	localparam int STATUS_W   = 2;

	// Configuration register block.
	localparam int BCNT_W     = 11;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;
	localparam int REG_SEL_LSB = 2;

	localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(1024);
	localparam int MAX_BLOCKS_DEF = 1024;
	localparam logic [BLK_W-1:0] COUNT_MAX = {BLK_W{1'b1}};

	// Register index of block_count.
	localparam logic [APB_AW-REG_SEL_LSB-1:0] REG_BLOCK_COUNT = '0;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_FORMAT = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNFORMATTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE     = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/fbla_if.sv -----
`default_nettype none
interface fbla_req_if;
	import fbla_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [BLK_W-1:0] block_index;

	modport source (output valid, output operation, output block_index, input ready);
	modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface fbla_rsp_if;
	import fbla_pkg::*;

	logic                valid;
	logic                ready;
	logic [BLK_W-1:0]    granted_block;
	logic [BLK_W-1:0]    free_count;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output granted_block, output free_count, output status,
		input ready);
	modport sink   (input valid, input granted_block, input free_count, input status,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/fbla_ram.sv -----
`default_nettype none
module fbla_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/fbla_apb.sv -----
`default_nettype none
module fbla_apb (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fbla_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fbla_pkg::APB_DW-1:0]   pwdata,
	output logic      [fbla_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output logic      [fbla_pkg::BCNT_W-1:0]   block_count
);
	import fbla_pkg::*;

	logic [BCNT_W-1:0] block_count_q;
	logic              sel_bcnt;

	// All registers are word aligned, so the low address bits are ignored.
	assign sel_bcnt = (paddr[APB_AW-1:REG_SEL_LSB] == REG_BLOCK_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BCNT_RESET;
		end else if (psel && penable && pwrite && pready && sel_bcnt) begin
			block_count_q <= pwdata[BCNT_W-1:0];
		end
	end

	assign pready      = 1'b1;
	assign prdata      = sel_bcnt ? APB_DW'(block_count_q) : '0;
	assign block_count = block_count_q;

endmodule
`default_nettype wire

// ----- rtl/free_block_list_allocator.sv -----
`default_nettype none
// Free block allocator for a volume of up to MAX_BLOCKS blocks. The free blocks form a singly
// linked list whose next pointers live in one synchronous RAM; the list head, the free count
// and a formatted flag sit in registers. Block zero is reserved and, as a head value, marks
// the list empty. Each item on req carries an operation: format chains blocks 1 to n-1 with
// n = min(block_count, MAX_BLOCKS), allocate pops the head and returns it in granted_block,
// free pushes block_index onto the list. Every item produces exactly one result on rsp, with
// the free count after the operation and a status (ok, not formatted, no free block).
// Allocate passes through S_ALLOC, since the head's next pointer comes out of the RAM's registered
// read port in the cycle after its address is applied; free and all other operations register
// their result at the accepting edge, where the pointer write of free also goes to the RAM. Format
// writes one next pointer per cycle after the accepting edge, for entries 1 to n-1 in turn; when n
// is below two it writes none and registers its result at the accepting edge. The block works on
// one item at a time, taking a new one only when the result register is empty or being drained.
// block_count is written through the APB port at byte address 0 and must only change while
// the block is idle. The pointer RAM is not cleared at reset; it is fully defined by format.
// Double frees are not detected, and the free count saturates at 1023.
module free_block_list_allocator #(
	parameter int MAX_BLOCKS = fbla_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fbla_pkg::APB_AW-1:0] paddr,
	input  wire logic [fbla_pkg::APB_DW-1:0] pwdata,
	output logic      [fbla_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	fbla_req_if.sink                         req,
	fbla_rsp_if.source                       rsp
);
	import fbla_pkg::*;

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int NW = AW + 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ALLOC = 2'd1;
	localparam logic [1:0] S_FMT   = 2'd2;

	logic [BCNT_W-1:0] block_count;

	// Control state.
	logic [1:0]       state_q;
	logic [BLK_W-1:0] head_q;
	logic [BLK_W-1:0] free_q;
	logic             fmt_q;
	logic [AW-1:0]    fmt_idx_q;
	logic [NW-1:0]    fmt_n_q;

	// Result register.
	logic                out_valid_q;
	logic [BLK_W-1:0]    granted_q;
	logic [BLK_W-1:0]    free_out_q;
	logic [STATUS_W-1:0] status_q;

	// Pointer RAM ports.
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [BLK_W-1:0] mem_wdata;
	logic [BLK_W-1:0] mem_rdata;

	logic             accept;
	logic             blk_ok;
	logic [NW-1:0]    n_eff;
	logic [NW-1:0]    fmt_succ;
	logic             fmt_last;
	logic [BLK_W-1:0] fmt_count;
	logic [BLK_W-1:0] free_dec;
	logic [BLK_W-1:0] free_inc;

	fbla_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.block_count (block_count)
	);

	fbla_ram #(
		.WIDTH (BLK_W),
		.DEPTH (MAX_BLOCKS)
	) u_next_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (AW'(head_q)),
		.rdata (mem_rdata)
	);

	// A new item is taken only in idle and only when the result slot is empty or frees up this cycle.
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Blocks at or above MAX_BLOCKS and block zero are silently ignored by free.
	assign blk_ok = (req.block_index != '0) && (32'(req.block_index) < MAX_BLOCKS);

	// Effective volume size: the configured count clipped to the RAM depth.
	always_comb begin
		if (32'(block_count) > MAX_BLOCKS) begin
			n_eff = NW'(MAX_BLOCKS);
		end else begin
			n_eff = NW'(block_count);
		end
	end

	// During format, entry i points at i+1, and the last entry ends the chain.
	assign fmt_succ = NW'(fmt_idx_q) + NW'(1);
	assign fmt_last = (fmt_succ == fmt_n_q);

	always_comb begin
		if (32'(fmt_n_q) - 32'd1 > 32'(COUNT_MAX)) begin
			fmt_count = COUNT_MAX;
		end else begin
			fmt_count = BLK_W'(fmt_n_q - NW'(1));
		end
	end

	assign free_dec = (free_q != '0) ? free_q - BLK_W'(1) : '0;
	assign free_inc = (free_q != COUNT_MAX) ? free_q + BLK_W'(1) : free_q;

	// Pointer writes: one per cycle while formatting, or the push of a freed block.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fmt_idx_q;
		mem_wdata = fmt_last ? '0 : BLK_W'(fmt_succ);
		if (state_q == S_FMT) begin
			mem_we = 1'b1;
		end else if (accept && req.operation == OP_FREE && fmt_q && blk_ok) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(req.block_index);
			mem_wdata = head_q;
		end
	end

	// A result can only be pending in idle, so the drain is handled there. At an accepting
	// edge the old result is either gone already or leaves at that same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			free_q      <= '0;
			fmt_q       <= 1'b0;
			fmt_idx_q   <= '0;
			fmt_n_q     <= '0;
			out_valid_q <= 1'b0;
			granted_q   <= '0;
			free_out_q  <= '0;
			status_q    <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						granted_q <= '0;
						if (req.operation == OP_FORMAT) begin
							fmt_q    <= 1'b1;
							status_q <= ST_OK;
							if (n_eff < NW'(2)) begin
								head_q      <= '0;
								free_q      <= '0;
								free_out_q  <= '0;
								out_valid_q <= 1'b1;
							end else begin
								fmt_idx_q   <= AW'(1);
								fmt_n_q     <= n_eff;
								state_q     <= S_FMT;
								out_valid_q <= 1'b0;
							end
						end else if (req.operation == OP_ALLOC) begin
							free_out_q <= free_q;
							if (!fmt_q) begin
								status_q    <= ST_UNFORMATTED;
								out_valid_q <= 1'b1;
							end else if (head_q == '0) begin
								status_q    <= ST_NO_FREE;
								out_valid_q <= 1'b1;
							end else begin
								// The RAM latches next_table[head] at this edge.
								status_q    <= ST_OK;
								state_q     <= S_ALLOC;
								out_valid_q <= 1'b0;
							end
						end else if (req.operation == OP_FREE) begin
							out_valid_q <= 1'b1;
							if (!fmt_q) begin
								status_q   <= ST_UNFORMATTED;
								free_out_q <= free_q;
							end else if (blk_ok) begin
								status_q   <= ST_OK;
								head_q     <= req.block_index;
								free_q     <= free_inc;
								free_out_q <= free_inc;
							end else begin
								status_q   <= ST_OK;
								free_out_q <= free_q;
							end
						end else begin
							status_q    <= ST_OK;
							free_out_q  <= free_q;
							out_valid_q <= 1'b1;
						end
					end else if (rsp.valid && rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_ALLOC: begin
					granted_q   <= head_q;
					free_q      <= free_dec;
					free_out_q  <= free_dec;
					head_q      <= (free_dec == '0) ? '0 : mem_rdata;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FMT: begin
					fmt_idx_q <= AW'(fmt_succ);
					if (fmt_last) begin
						head_q      <= BLK_W'(1);
						free_q      <= fmt_count;
						free_out_q  <= fmt_count;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_block = granted_q;
	assign rsp.free_count    = free_out_q;
	assign rsp.status        = status_q;

	// An empty count always comes with an empty head.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q == '0) |-> (head_q == '0))
		else $error("free count is zero but the list head is not");

	// The pointer read of an allocate must not collide with a pointer write, and no result is pending.
	a_alloc_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> (!mem_we && !out_valid_q))
		else $error("write or pending result during allocate read");

	// A valid free leaves the freed block at the head of the list.
	a_free_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_FREE && fmt_q && blk_ok)
		|=> (head_q == $past(req.block_index)))
		else $error("freed block did not become the list head");

	// Format never leaves the block idle without a result.
	a_fmt_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FMT && fmt_last) |=> (state_q == S_IDLE && out_valid_q && fmt_q))
		else $error("format finished without a result");

endmodule
`default_nettype wire
